[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while rst is high.
`define BIS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Property checked on every rising clock edge, reset included.
`define BIS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

[rtl/bis_pkg.sv]
// Shared constants, types and the per-character scan step of the IPv4 text scanner.
package bis_pkg;

   localparam int unsigned MAX_TEXT        = 16;
   localparam int unsigned HOST_OFFSET     = 15;
   localparam int unsigned FOUND_LEN_LIMIT = 16;
   localparam int unsigned OCTET_MAX       = 255;
   localparam int unsigned LEN_W           = $clog2(MAX_TEXT + 2);
   localparam int unsigned POS_W           = 4;
   localparam int unsigned OCT_W           = 10;

   localparam logic [7:0] CH_PAREN   = 8'h28;  // (
   localparam logic [7:0] CH_BRACKET = 8'h5B;  // [
   localparam logic [7:0] CH_AT      = 8'h40;  // @
   localparam logic [7:0] CH_DOT     = 8'h2E;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;

   // digit_phase: 0 outside an octet, 1..3 digits taken + 1, 4 octet full
   localparam logic [2:0] PH_OUT        = 3'd0;
   localparam logic [2:0] PH_FIRST      = 3'd1;
   localparam logic [2:0] PH_LAST_DIGIT = 3'd3;

   localparam logic [2:0] DOTS_FULL = 3'd3;
   localparam logic [2:0] DOT_STOP  = 3'd4;

   typedef struct packed {
      logic                        stopped;
      logic                        tail_digit;
      logic [2:0]                  digit_phase;
      logic [2:0]                  dot_count;
      logic [LEN_W-1:0]            text_length;
      logic [3:0][OCT_W-1:0]       octets;
   } scan_state_type;

   typedef struct packed {
      scan_state_type st;
      logic           consumed;
   } scan_result_type;

   // line state handed to the end-of-line stage
   typedef struct packed {
      logic           held_valid;
      logic [7:0]     held_char;
      scan_state_type st;
   } line_snap_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // One scan of character c against lookahead la (la_ok low at end of line).
   function automatic scan_result_type scan_step(input scan_state_type s,
                                                 input logic [7:0]     c,
                                                 input logic           la_ok,
                                                 input logic [7:0]     la);
      scan_result_type  r;
      logic [1:0]       idx;
      logic [OCT_W-1:0] cur;
      r          = '{st: s, consumed: 1'b0};
      idx        = s.dot_count[1:0];
      cur        = s.octets[idx];
      priority if (s.stopped) begin
         r.consumed = 1'b0;
      end else if (c == CH_PAREN || c == CH_BRACKET || c == CH_AT) begin
         if (la_ok && is_digit(la)) begin
            r.st.digit_phase = PH_FIRST;
            r.st.dot_count   = '0;
            r.st.text_length = '0;
            r.st.octets      = '0;
            r.st.tail_digit  = 1'b0;
         end
      end else if (s.digit_phase == PH_OUT || s.digit_phase > PH_LAST_DIGIT) begin
         r.consumed = 1'b0;
      end else if (!is_digit(c)) begin
         r.st.digit_phase = PH_OUT;
      end else if (s.text_length >= LEN_W'(MAX_TEXT)) begin
         r.st.stopped = 1'b1;
      end else begin
         // value * 10 + digit; three digits at most, so 10 bits never wrap
         r.st.octets[idx] = {cur[OCT_W-4:0], 3'b000} + {cur[OCT_W-2:0], 1'b0}
                            + OCT_W'(c[3:0]);
         if (s.dot_count >= DOTS_FULL) begin
            r.st.tail_digit = 1'b1;
         end
         r.st.text_length = s.text_length + LEN_W'(1);
         r.st.digit_phase = s.digit_phase + 3'd1;
         if (la_ok && la == CH_DOT) begin
            if (s.dot_count >= DOTS_FULL) begin
               r.st.dot_count = DOT_STOP;
               r.st.stopped   = 1'b1;
            end else begin
               r.st.dot_count   = s.dot_count + 3'd1;
               r.st.text_length = s.text_length + LEN_W'(2);
               r.st.digit_phase = PH_FIRST;
               r.consumed       = 1'b1;
            end
         end
      end
      return r;
   endfunction

endpackage

[rtl/bis_finish.sv]
// End-of-line step: scans the held character, validates the candidate and packs it.
module bis_finish (
   input  bis_pkg::line_snap_type snap,
   output logic                   found,
   output logic [31:0]            address
);

   bis_pkg::scan_result_type tail;
   bis_pkg::scan_state_type  st;
   logic                     octets_ok;

   always_comb begin
      tail = bis_pkg::scan_step(snap.st, snap.held_char, 1'b0, 8'h00);
      st   = snap.held_valid ? tail.st : snap.st;
   end

   always_comb begin
      octets_ok = 1'b1;
      for (int k = 0; k < 4; k++) begin
         if (st.octets[k] > bis_pkg::OCT_W'(bis_pkg::OCTET_MAX)) begin
            octets_ok = 1'b0;
         end
      end
   end

   always_comb begin
      found = (st.dot_count == bis_pkg::DOTS_FULL) && st.tail_digit
              && (st.text_length < bis_pkg::LEN_W'(bis_pkg::FOUND_LEN_LIMIT))
              && octets_ok;
      address = found ? {st.octets[0][7:0], st.octets[1][7:0],
                         st.octets[2][7:0], st.octets[3][7:0]} : 32'h0;
   end

endmodule

[rtl/bracketed_ipv4_text_scanner.sv]
// Top level of the bracketed IPv4 text scanner.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+---------------------------------
//   req     | in  | req_tvalid/req_tready  | tdata = ch, tlast = end of line
//   rsp     | out | rsp_tvalid/rsp_tready  | tdata = address, tuser = found
//   csr     | in  | csr_wr_en              | csr_wr_data = reverse_check
//
// One character per cycle, back to back unless req stalls; the scan step
// (multiply by ten and a few counters) sits between the input register and
// the line state registers. Results pass the end-of-line and result registers.
// Reset is synchronous: clears valid bits, line state and the reverse-check bit.
// A result waiting on rsp_tready holds while the next line streams in; the
// last character of a third line waits in the input register and stalls req.
module bracketed_ipv4_text_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] ch
   input  logic        req_tlast,   // last character of the line
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] address
   output logic        rsp_tuser,   // [0] found
   input  logic        csr_wr_en,
   input  logic        csr_wr_data  // reverse_check
);

   // configuration
   logic rev_ff;

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff;
   logic       in_last_ff;

   // line state
   logic                           held_valid_ff, held_valid_in;
   logic [7:0]                     held_char_ff, held_char_in;
   logic [bis_pkg::POS_W-1:0]      pos_ff, pos_in;
   logic                           skip_host_ff, skip_host_in;
   bis_pkg::scan_state_type        scan_ff, scan_in;
   bis_pkg::scan_result_type       step;
   logic                           do_feed;

   // end-of-line stage
   logic                   fin_valid_ff, fin_valid_in;
   bis_pkg::line_snap_type fin_snap_ff, fin_snap_in;
   logic                   fin_found;
   logic [31:0]            fin_address;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_found_ff;
   logic [31:0] rsp_addr_ff;

   logic rsp_free, fin_free, a_fire, in_free, req_xfer;

   // flow control: a character only waits when it ends a line and the
   // end-of-line stage is still blocked by an untaken result
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign fin_free = !fin_valid_ff || rsp_free;
   assign a_fire   = in_valid_ff && (!in_last_ff || fin_free);
   assign in_free  = !in_valid_ff || a_fire;
   assign req_xfer = req_tvalid && in_free;

   assign req_tready = in_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_addr_ff;
   assign rsp_tuser  = rsp_found_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rev_ff <= 1'b0;
      end else if (csr_wr_en) begin
         rev_ff <= csr_wr_data;
      end
   end

   // input register
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_xfer) begin
         in_valid_in = 1'b1;
      end else if (a_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_ch_ff   <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // per-character update: prefix/hostname skip, then feed with lookahead
   always_comb begin
      held_valid_in = held_valid_ff;
      held_char_in  = held_char_ff;
      pos_in        = pos_ff;
      skip_host_in  = skip_host_ff;
      scan_in       = scan_ff;
      do_feed       = 1'b0;
      step          = bis_pkg::scan_step(scan_ff, held_char_ff, 1'b1, in_ch_ff);

      if (rev_ff && !skip_host_ff) begin
         if (pos_ff < bis_pkg::POS_W'(bis_pkg::HOST_OFFSET)) begin
            pos_in = pos_ff + bis_pkg::POS_W'(1);
         end else if (in_ch_ff == bis_pkg::CH_SPACE) begin
            skip_host_in = 1'b1;
            do_feed      = 1'b1;
         end
      end else begin
         do_feed = 1'b1;
      end

      if (do_feed) begin
         if (held_valid_ff) begin
            scan_in = step.st;
            if (step.consumed) begin
               // the dot was taken as lookahead, nothing left to hold
               held_valid_in = 1'b0;
            end else begin
               held_char_in = in_ch_ff;
            end
         end else begin
            held_char_in  = in_ch_ff;
            held_valid_in = 1'b1;
         end
      end

      fin_snap_in = '{held_valid: held_valid_in, held_char: held_char_in, st: scan_in};
   end

   // line state clears after the last character of each line
   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_char_ff  <= '0;
         pos_ff        <= '0;
         skip_host_ff  <= 1'b0;
         scan_ff       <= '0;
      end else if (a_fire) begin
         if (in_last_ff) begin
            held_valid_ff <= 1'b0;
            held_char_ff  <= '0;
            pos_ff        <= '0;
            skip_host_ff  <= 1'b0;
            scan_ff       <= '0;
         end else begin
            held_valid_ff <= held_valid_in;
            held_char_ff  <= held_char_in;
            pos_ff        <= pos_in;
            skip_host_ff  <= skip_host_in;
            scan_ff       <= scan_in;
         end
      end
   end

   // end-of-line stage
   always_comb begin
      fin_valid_in = fin_valid_ff;
      if (a_fire && in_last_ff) begin
         fin_valid_in = 1'b1;
      end else if (rsp_free) begin
         fin_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= fin_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (a_fire && in_last_ff) begin
         fin_snap_ff <= fin_snap_in;
      end
   end

   bis_finish u_finish (
      .snap    (fin_snap_ff),
      .found   (fin_found),
      .address (fin_address)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_free ? fin_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free && fin_valid_ff) begin
         rsp_found_ff <= fin_found;
         rsp_addr_ff  <= fin_address;
      end
   end

endmodule

[rtl/bis_checker.sv]
// Port-level checks for the IPv4 text scanner, bound to its top level.
`include "assert_macros.svh"

module bis_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a result not taken stays offered
   `BIS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)

   // and keeps its payload
   `BIS_ASSERT(a_rsp_stable_data, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
   `BIS_ASSERT(a_rsp_stable_flag, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tuser))

   // a line without an address reports a zero address
   `BIS_ASSERT(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tuser |-> rsp_tdata == 32'h0)

   // nothing is offered in the cycle after reset
   `BIS_ASSERT_ALWAYS(a_reset_clear, clock, !reset && $past(reset) |-> !rsp_tvalid)

endmodule

bind bracketed_ipv4_text_scanner bis_checker u_bis_checker (.*);
